// ----- sv/rvk_pkg.sv -----
// Shared types, constants and helpers for the velocity kick block.
`default_nettype none

package rvk_pkg;

    // fraction bits of the force inputs
    localparam int FORCE_FRAC_BITS = 16;

    // pipelined unit depths
    localparam int SQRT_STAGES = 32;
    localparam int DIV_STAGES  = 62;

    typedef struct packed {
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic        [31:0] density;
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
    } t_in;

    typedef struct packed {
        logic signed [31:0] new_vel_x;
        logic signed [31:0] new_vel_y;
        logic signed [31:0] new_vel_z;
        logic        [31:0] new_density;
        logic               bad_speed;
    } t_out;

    // magnitude of a 32-bit two's complement value
    function automatic logic [31:0] mag32(input logic [31:0] x);
        mag32 = x[31] ? (32'd0 - x) : x;
    endfunction

    // number of significant bits
    function automatic logic [6:0] bit_len(input logic [63:0] x);
        logic [6:0] n;
        n = 7'd0;
        for (int i = 0; i < 64; i++) begin
            if (x[i]) begin
                n = 7'(i + 1);
            end
        end
        bit_len = n;
    endfunction

endpackage

`default_nettype wire

// ----- sv/rvk_isqrt.sv -----
// Pipelined floor integer square root, one result bit per stage.
`default_nettype none

module rvk_isqrt (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_vld,
    input  wire logic [63:0] i_rad,
    output logic             o_vld,
    output logic [31:0]      o_root
);

    localparam int N = rvk_pkg::SQRT_STAGES;

    logic [N-1:0] r_v;
    logic [63:0]  r_x [N];
    logic [63:0]  r_r [N];
    logic [63:0]  x_in [N];
    logic [63:0]  q_in [N];
    logic [63:0]  n_x [N];
    logic [63:0]  n_r [N];
    logic [63:0]  trial [N];
    logic [63:0]  bitv [N];

    always_comb begin
        x_in[0] = i_rad;
        q_in[0] = '0;
        for (int g = 1; g < N; g++) begin
            x_in[g] = r_x[g-1];
            q_in[g] = r_r[g-1];
        end
        for (int g = 0; g < N; g++) begin
            bitv[g]  = 64'd1 << (62 - 2 * g);
            trial[g] = q_in[g] + bitv[g];
            if (x_in[g] >= trial[g]) begin
                n_x[g] = x_in[g] - trial[g];
                n_r[g] = (q_in[g] >> 1) + bitv[g];
            end else begin
                n_x[g] = x_in[g];
                n_r[g] = q_in[g] >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[N-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int g = 0; g < N; g++) begin
            r_x[g] <= n_x[g];
            r_r[g] <= n_r[g];
        end
    end

    assign o_vld  = r_v[N-1];
    assign o_root = r_r[N-1][31:0];

endmodule

`default_nettype wire

// ----- sv/rvk_div.sv -----
// Pipelined restoring divider, 62-bit dividend by 32-bit divisor.
`default_nettype none

module rvk_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_vld,
    input  wire logic [61:0] i_num,
    input  wire logic [31:0] i_den,
    output logic             o_vld,
    output logic [61:0]      o_quo
);

    localparam int N = rvk_pkg::DIV_STAGES;

    logic [N-1:0] r_v;
    logic [31:0]  r_rem [N];
    logic [61:0]  r_dq  [N];
    logic [31:0]  r_den [N];
    logic [31:0]  rem_in [N];
    logic [61:0]  dq_in  [N];
    logic [31:0]  den_in [N];
    logic [32:0]  trial  [N];
    logic [31:0]  n_rem  [N];
    logic [61:0]  n_dq   [N];

    always_comb begin
        rem_in[0] = '0;
        dq_in[0]  = i_num;
        den_in[0] = i_den;
        for (int g = 1; g < N; g++) begin
            rem_in[g] = r_rem[g-1];
            dq_in[g]  = r_dq[g-1];
            den_in[g] = r_den[g-1];
        end
        for (int g = 0; g < N; g++) begin
            trial[g] = {rem_in[g], dq_in[g][61]};
            if (trial[g] >= {1'b0, den_in[g]}) begin
                n_rem[g] = 32'(trial[g] - {1'b0, den_in[g]});
                n_dq[g]  = {dq_in[g][60:0], 1'b1};
            end else begin
                n_rem[g] = trial[g][31:0];
                n_dq[g]  = {dq_in[g][60:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[N-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int g = 0; g < N; g++) begin
            r_rem[g] <= n_rem[g];
            r_dq[g]  <= n_dq[g];
            r_den[g] <= den_in[g];
        end
    end

    assign o_vld = r_v[N-1];
    assign o_quo = r_dq[N-1];

endmodule

`default_nettype wire

// ----- sv/relativistic_velocity_kick.sv -----
// Top level: velocity kick for one grid cell per beat, Newtonian or relativistic.
//
// Input channel: a cell beat (velocity, density, force) is taken at a rising edge
// with start high and busy low. busy never rises, so a beat may enter on every
// clock: the block is fully pipelined and sustains one cell per cycle.
// Result channel: o_strobe marks o_result for exactly one cycle; the receiver
// must take it then, as nothing downstream can hold the pipe.
// Every mode follows the same path from the accepting edge to the edge that loads
// o_result. The path is set by the two 32-stage square root units
// (2-D Lorentz factor, then the normalising root) and the 62-stage dividers
// that run all four quotients side by side.
// Config: APB writes take a setup and an access phase; pready is tied high.
// Registers at byte 0 (dt), 4 (three_dimensional), 8 (fluid_model). Write them
// only while no beat is in flight.
// Reset: synchronous, active low. Clears every valid bit in the pipe and loads
// dt = 0, three_dimensional = 1, fluid_model = 0.
`default_nettype none

module relativistic_velocity_kick (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire rvk_pkg::t_in  i_item,
    output logic               o_strobe,
    output rvk_pkg::t_out      o_result,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [3:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int SQ     = rvk_pkg::SQRT_STAGES;
    localparam int DV     = rvk_pkg::DIV_STAGES;
    localparam int FFB    = rvk_pkg::FORCE_FRAC_BITS;
    localparam int NSH    = FFB - 14;
    localparam int NSH_R  = (NSH > 0) ? NSH : 0;
    localparam int NSH_L  = (NSH < 0) ? -NSH : 0;
    localparam int KSH    = FFB + 46;
    // kicked w waits at stage 6 until the 2-D root lands at stage SQ+2
    localparam int W_DLY  = SQ - 4;

    localparam logic [63:0] ONE_Q60  = 64'd1 << 60;
    localparam logic [63:0] TERM_CAP = 64'd1 << 62;

    typedef enum logic [1:0] {
        REG_DT    = 2'd0,
        REG_3D    = 2'd1,
        REG_MODEL = 2'd2,
        REG_NONE  = 2'd3
    } t_reg_idx;

    // side data that rides alongside the arithmetic
    typedef struct packed {
        logic                use_byp;
        rvk_pkg::t_out       byp;
        logic [31:0]         rho;
        logic                is3d;
        logic [31:0]         vz;
        logic [60:0]         s;
        logic [2:0]          wneg;
        logic [5:0]          k;
        logic [2:0][30:0]    msh;
    } t_side;

    // ---------------------------------------------------------------- config
    logic [31:0] r_dt;
    logic        r_3d;
    logic        r_model;
    t_reg_idx    reg_idx;

    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt    <= '0;
            r_3d    <= 1'b1;
            r_model <= 1'b0;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                REG_DT:    r_dt    <= pwdata;
                REG_3D:    r_3d    <= pwdata[0];
                REG_MODEL: r_model <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_DT:    prdata = r_dt;
            REG_3D:    prdata = {31'd0, r_3d};
            REG_MODEL: prdata = {31'd0, r_model};
            default:   prdata = '0;
        endcase
    end

    assign busy = 1'b0;

    logic accept;
    assign accept = start && !busy;

    // ---------------------------------------------------------------- stage 1
    // squares of the speeds and |F|*dt
    logic [2:0][31:0] in_v, in_f;
    assign in_v = {i_item.vel_z, i_item.vel_y, i_item.vel_x};
    assign in_f = {i_item.force_z, i_item.force_y, i_item.force_x};

    logic             r1_vld;
    rvk_pkg::t_in     r1_in;
    logic [63:0]      r1_vsq [3];
    logic [63:0]      r1_fd  [3];
    logic             r1_model, r1_3d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_in    <= i_item;
        r1_model <= r_model;
        r1_3d    <= r_3d;
        for (int i = 0; i < 3; i++) begin
            r1_vsq[i] <= 64'(rvk_pkg::mag32(in_v[i])) * 64'(rvk_pkg::mag32(in_v[i]));
            r1_fd[i]  <= 64'(rvk_pkg::mag32(in_f[i])) * 64'(r_dt);
        end
    end

    // ---------------------------------------------------------------- stage 2
    // speed check, s = 1 - v^2, Newtonian kick and the bypass result
    logic [2:0][31:0]   r1_v, r1_f;
    logic [63:0]        v2;
    logic               bad2;
    logic [63:0]        nk_m   [3];
    logic [63:0]        nk_pre [3];
    logic signed [64:0] nk_sum [3];
    logic [31:0]        nk_res [3];
    t_side              n_side2;

    assign r1_v = {r1_in.vel_z, r1_in.vel_y, r1_in.vel_x};
    assign r1_f = {r1_in.force_z, r1_in.force_y, r1_in.force_x};

    always_comb begin
        v2   = r1_vsq[0] + r1_vsq[1] + r1_vsq[2];
        bad2 = r1_model && (v2 >= ONE_Q60);
        for (int i = 0; i < 3; i++) begin
            nk_pre[i] = r1_fd[i] >> NSH_R;
            if (nk_pre[i] > (TERM_CAP >> NSH_L)) begin
                nk_m[i] = TERM_CAP;
            end else begin
                nk_m[i] = nk_pre[i] << NSH_L;
            end
            if (r1_f[i][31]) begin
                nk_sum[i] = $signed({{33{r1_v[i][31]}}, r1_v[i]}) - $signed({1'b0, nk_m[i]});
            end else begin
                nk_sum[i] = $signed({{33{r1_v[i][31]}}, r1_v[i]}) + $signed({1'b0, nk_m[i]});
            end
            if (nk_sum[i] > 65'sd2147483647) begin
                nk_res[i] = 32'h7FFF_FFFF;
            end else if (nk_sum[i] < -65'sd2147483648) begin
                nk_res[i] = 32'h8000_0000;
            end else begin
                nk_res[i] = nk_sum[i][31:0];
            end
        end

        n_side2         = '0;
        n_side2.rho     = r1_in.density;
        n_side2.is3d    = r1_3d;
        n_side2.vz      = r1_in.vel_z;
        n_side2.s       = 61'(ONE_Q60 - v2);
        n_side2.use_byp = !r1_model || bad2;
        if (!r1_model) begin
            n_side2.byp.new_vel_x   = nk_res[0];
            n_side2.byp.new_vel_y   = nk_res[1];
            n_side2.byp.new_vel_z   = r1_3d ? nk_res[2] : r1_in.vel_z;
            n_side2.byp.new_density = r1_in.density;
            n_side2.byp.bad_speed   = 1'b0;
        end else begin
            n_side2.byp.new_vel_x   = r1_in.vel_x;
            n_side2.byp.new_vel_y   = r1_in.vel_y;
            n_side2.byp.new_vel_z   = r1_in.vel_z;
            n_side2.byp.new_density = r1_in.density;
            n_side2.byp.bad_speed   = bad2;
        end
    end

    logic        r2_vld;
    t_side       r2_side;
    logic [63:0] r2_fd   [3];
    logic [31:0] r2_v    [3];
    logic        r2_fneg [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_side <= n_side2;
        for (int i = 0; i < 3; i++) begin
            r2_fd[i]   <= r1_fd[i];
            r2_v[i]    <= r1_v[i];
            r2_fneg[i] <= r1_f[i][31];
        end
    end

    // ---------------------------------------------------------- stages 3 to 6
    // term = (|F|*dt * s) >> KSH, 64 x 61 product in four partial products
    logic [63:0]  r3_ll [3];
    logic [60:0]  r3_lh [3];
    logic [63:0]  r3_hl [3];
    logic [60:0]  r3_hh [3];
    logic [31:0]  r3_v  [3];
    logic         r3_fneg [3];
    logic [64:0]  r4_mid [3];
    logic [63:0]  r4_ll  [3];
    logic [60:0]  r4_hh  [3];
    logic [31:0]  r4_v   [3];
    logic         r4_fneg [3];
    logic [124:0] r5_prod [3];
    logic [31:0]  r5_v    [3];
    logic         r5_fneg [3];
    logic [2:0][63:0] r6_w;
    logic [124:0] t_raw [3];
    logic [63:0]  t_cap [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            t_raw[i] = r5_prod[i] >> KSH;
            t_cap[i] = (t_raw[i] > 125'(TERM_CAP)) ? TERM_CAP : t_raw[i][63:0];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r3_ll[i]   <= 64'(r2_fd[i][31:0])  * 64'(r2_side.s[31:0]);
            r3_lh[i]   <= 61'(r2_fd[i][31:0])  * 61'(r2_side.s[60:32]);
            r3_hl[i]   <= 64'(r2_fd[i][63:32]) * 64'(r2_side.s[31:0]);
            r3_hh[i]   <= 61'(r2_fd[i][63:32]) * 61'(r2_side.s[60:32]);
            r3_v[i]    <= r2_v[i];
            r3_fneg[i] <= r2_fneg[i];

            r4_mid[i]  <= 65'(r3_lh[i]) + 65'(r3_hl[i]);
            r4_ll[i]   <= r3_ll[i];
            r4_hh[i]   <= r3_hh[i];
            r4_v[i]    <= r3_v[i];
            r4_fneg[i] <= r3_fneg[i];

            r5_prod[i] <= {r4_hh[i], r4_ll[i]} + (125'(r4_mid[i]) << 32);
            r5_v[i]    <= r4_v[i];
            r5_fneg[i] <= r4_fneg[i];

            if (r5_fneg[i]) begin
                r6_w[i] <= {{32{r5_v[i][31]}}, r5_v[i]} - t_cap[i];
            end else begin
                r6_w[i] <= {{32{r5_v[i][31]}}, r5_v[i]} + t_cap[i];
            end
        end
    end

    // w and side data wait for the 2-D root
    logic [2:0][63:0] r_wd  [W_DLY];
    t_side            r_sda [SQ];

    always_ff @(posedge i_clk) begin
        r_wd[0]  <= r6_w;
        r_sda[0] <= r2_side;
        for (int j = 1; j < W_DLY; j++) begin
            r_wd[j] <= r_wd[j-1];
        end
        for (int j = 1; j < SQ; j++) begin
            r_sda[j] <= r_sda[j-1];
        end
    end

    // sqrt(s) for the unkicked z lane in 2-D
    logic        sqa_vld;
    logic [31:0] sqa_root;

    rvk_isqrt u_sqa (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r2_vld),
        .i_rad   (64'(r2_side.s)),
        .o_vld   (sqa_vld),
        .o_root  (sqa_root)
    );

    // ---------------------------------------------------------- stage SQ+3
    t_side       sd_a;
    logic [63:0] z_mag;
    logic [63:0] z_w;

    assign sd_a  = r_sda[SQ-1];
    assign z_mag = (64'(sqa_root) * 64'(rvk_pkg::mag32(sd_a.vz))) >> 30;
    assign z_w   = sd_a.vz[31] ? (64'd0 - z_mag) : z_mag;

    logic             r35_vld;
    t_side            r35_side;
    logic [2:0][63:0] r35_w;

    // ------------------------------------------------- normalise and square
    logic             r36_vld, r37_vld, r38_vld, r39_vld, r40_vld;
    t_side            r36_side, r37_side, r38_side, r39_side;
    t_side            n_side36, n_side37, n_side38;
    logic [63:0]      r36_m [3];
    logic [63:0]      r37_m [3];
    logic [60:0]      r38_ssh;
    logic [60:0]      r39_ssh;
    logic [61:0]      r39_sq [3];
    logic [63:0]      r40_sum;
    t_side            r40_side;
    logic [6:0]       bl   [3];
    logic [6:0]       bl_mx;
    logic [5:0]       k37;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            bl[i] = rvk_pkg::bit_len(r36_m[i]);
        end
        bl_mx = bl[0];
        if (bl[1] > bl_mx) begin
            bl_mx = bl[1];
        end
        if (bl[2] > bl_mx) begin
            bl_mx = bl[2];
        end
        k37 = (bl_mx > 7'd31) ? 6'(bl_mx - 7'd31) : 6'd0;
    end

    // side data for the next three stages, with the fields each one fills in
    always_comb begin
        n_side36 = r35_side;
        for (int i = 0; i < 3; i++) begin
            n_side36.wneg[i] = r35_w[i][63];
        end
        n_side37   = r36_side;
        n_side37.k = k37;
        n_side38   = r37_side;
        for (int i = 0; i < 3; i++) begin
            n_side38.msh[i] = 31'(r37_m[i] >> r37_side.k);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r35_vld <= 1'b0;
            r36_vld <= 1'b0;
            r37_vld <= 1'b0;
            r38_vld <= 1'b0;
            r39_vld <= 1'b0;
            r40_vld <= 1'b0;
        end else begin
            r35_vld <= sqa_vld;
            r36_vld <= r35_vld;
            r37_vld <= r36_vld;
            r38_vld <= r37_vld;
            r39_vld <= r38_vld;
            r40_vld <= r39_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r35_side  <= sd_a;
        r35_w[0]  <= r_wd[W_DLY-1][0];
        r35_w[1]  <= r_wd[W_DLY-1][1];
        r35_w[2]  <= sd_a.is3d ? r_wd[W_DLY-1][2] : z_w;

        r36_side  <= n_side36;
        for (int i = 0; i < 3; i++) begin
            r36_m[i] <= r35_w[i][63] ? (64'd0 - r35_w[i]) : r35_w[i];
        end

        r37_side <= n_side37;
        for (int i = 0; i < 3; i++) begin
            r37_m[i] <= r36_m[i];
        end

        r38_side <= n_side38;
        r38_ssh  <= r37_side.s >> {r37_side.k, 1'b0};

        r39_side <= r38_side;
        r39_ssh  <= r38_ssh;
        for (int i = 0; i < 3; i++) begin
            r39_sq[i] <= 62'(r38_side.msh[i]) * 62'(r38_side.msh[i]);
        end

        r40_side <= r39_side;
        r40_sum  <= 64'(r39_ssh) + 64'(r39_sq[0]) + 64'(r39_sq[1]) + 64'(r39_sq[2]);
    end

    // ------------------------------------------------------ normalising root
    logic        sqb_vld;
    logic [31:0] sqb_root;

    rvk_isqrt u_sqb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r40_vld),
        .i_rad   (r40_sum),
        .o_vld   (sqb_vld),
        .o_root  (sqb_root)
    );

    t_side r_sdb [SQ];
    t_side r_sdc [DV];

    always_ff @(posedge i_clk) begin
        r_sdb[0] <= r40_side;
        for (int j = 1; j < SQ; j++) begin
            r_sdb[j] <= r_sdb[j-1];
        end
        r_sdc[0] <= r_sdb[SQ-1];
        for (int j = 1; j < DV; j++) begin
            r_sdc[j] <= r_sdc[j-1];
        end
    end

    // ------------------------------------------------------------- dividers
    // divisor never zero: floor root of zero is forced to one lsb
    t_side       sd_b;
    logic [31:0] den;
    logic [3:0]  div_vld;
    logic [61:0] quo [4];

    assign sd_b = r_sdb[SQ-1];
    assign den  = (sqb_root == 32'd0) ? 32'd1 : sqb_root;

    for (genvar i = 0; i < 3; i++) begin : g_vdiv
        rvk_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (sqb_vld),
            .i_num   (62'(sd_b.msh[i]) << 30),
            .i_den   (den),
            .o_vld   (div_vld[i]),
            .o_quo   (quo[i])
        );
    end

    rvk_div u_rdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (sqb_vld),
        .i_num   ({sd_b.rho, 30'd0}),
        .i_den   (den),
        .o_vld   (div_vld[3]),
        .o_quo   (quo[3])
    );

    // ---------------------------------------------------------- output stage
    t_side         sd_c;
    logic [61:0]   rho_q;
    rvk_pkg::t_out n_out;
    logic [31:0]   res [3];

    assign sd_c  = r_sdc[DV-1];
    assign rho_q = quo[3] >> sd_c.k;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            res[i] = sd_c.wneg[i] ? (32'd0 - quo[i][31:0]) : quo[i][31:0];
        end
        if (sd_c.use_byp) begin
            n_out = sd_c.byp;
        end else begin
            n_out.new_vel_x   = res[0];
            n_out.new_vel_y   = res[1];
            n_out.new_vel_z   = res[2];
            n_out.new_density = (rho_q > 62'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : rho_q[31:0];
            n_out.bad_speed   = 1'b0;
        end
    end

    logic          r_strobe;
    rvk_pkg::t_out r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= div_vld[0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

    // ------------------------------------------------------------ assertions
    a_newton_no_flag : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !r_model) |-> !o_result.bad_speed)
        else $error("speed flag raised in Newtonian mode");

    a_root_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r40_vld |-> ##(rvk_pkg::SQRT_STAGES) sqb_vld)
        else $error("normalising root lost a beat");

    a_div_lanes : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (div_vld == 4'b0000) || (div_vld == 4'b1111))
        else $error("divider lanes out of step");

    a_div_to_strobe : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_vld[0] |=> o_strobe)
        else $error("quotient did not reach the result port");

endmodule

`default_nettype wire

// ----- tb/tb_relativistic_velocity_kick.sv -----
// Self-checking testbench for the relativistic velocity kick block.
`timescale 1ns / 100ps
`default_nettype none

module tb_relativistic_velocity_kick;

    localparam int LATENCY   = 135;
    localparam int N_RANDOM  = 1450;
    localparam int CYC_LIMIT = 400000;

    // register byte addresses
    localparam logic [3:0] ADDR_DT    = 4'd0;
    localparam logic [3:0] ADDR_3D    = 4'd4;
    localparam logic [3:0] ADDR_MODEL = 4'd8;

    localparam logic [63:0] ONE_Q60  = 64'd1 << 60;
    localparam logic [63:0] KICK_CAP = 64'd1 << 62;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          start = 1'b0;
    logic          busy;
    rvk_pkg::t_in  i_item = '0;
    logic          o_strobe;
    rvk_pkg::t_out o_result;
    logic          psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0]    paddr = '0;
    logic [31:0]   pwdata = '0;
    logic [31:0]   prdata;
    logic          pready;

    relativistic_velocity_kick dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_item(i_item),
        .o_strobe(o_strobe), .o_result(o_result), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #4 i_clk = ~i_clk;

    // local copy of the registers
    logic [31:0] dt_q;
    logic        is_3d;
    logic        is_rel;

    rvk_pkg::t_out kicked_q[$];
    int   n_errors = 0;
    int   cycle = 0;

    // ---------------------------------------------------------------- predictor
    function automatic logic [63:0] isqrt(input logic [63:0] x);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic signed [31:0] sat_s32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return 32'(v);
    endfunction

    function automatic logic signed [31:0] newton_step(input logic signed [31:0] v,
                                                      input logic signed [31:0] f);
        logic [63:0] m;
        logic signed [63:0] sum;
        m = (mag64(64'(f)) * 64'(dt_q)) >> (rvk_pkg::FORCE_FRAC_BITS - 14);
        if (m > KICK_CAP) m = KICK_CAP;
        sum = f < 0 ? 64'(v) - $signed(m) : 64'(v) + $signed(m);
        return sat_s32(sum);
    endfunction

    function automatic rvk_pkg::t_out kick_cell(input rvk_pkg::t_in c);
        rvk_pkg::t_out r;
        logic signed [31:0] v[3], f[3];
        logic signed [63:0] w[3];
        logic [63:0] m[3], v2, s, mx, sum, d, g, z, q, fd, t;
        logic [127:0] p;
        int k;
        v[0] = c.vel_x; v[1] = c.vel_y; v[2] = c.vel_z;
        f[0] = c.force_x; f[1] = c.force_y; f[2] = c.force_z;
        r.new_vel_x = c.vel_x; r.new_vel_y = c.vel_y; r.new_vel_z = c.vel_z;
        r.new_density = c.density;
        r.bad_speed = 1'b0;
        if (!is_rel) begin
            r.new_vel_x = newton_step(v[0], f[0]);
            r.new_vel_y = newton_step(v[1], f[1]);
            if (is_3d) r.new_vel_z = newton_step(v[2], f[2]);
            return r;
        end
        v2 = 0;
        for (int i = 0; i < 3; i++) v2 += mag64(64'(v[i])) * mag64(64'(v[i]));
        if (v2 >= ONE_Q60) begin
            r.bad_speed = 1'b1;
            return r;
        end
        s = ONE_Q60 - v2;
        for (int i = 0; i < 3; i++) begin
            if (i < 2 || is_3d) begin
                fd = mag64(64'(f[i])) * 64'(dt_q);
                p = {64'd0, fd} * {64'd0, s};
                p = p >> (rvk_pkg::FORCE_FRAC_BITS + 46);
                t = (p > {64'd0, KICK_CAP}) ? KICK_CAP : p[63:0];
                w[i] = f[i] < 0 ? 64'(v[i]) - $signed(t) : 64'(v[i]) + $signed(t);
            end
        end
        if (!is_3d) begin
            g = isqrt(s);
            z = (g * mag64(64'(v[2]))) >> 30;
            w[2] = v[2] < 0 ? -$signed(z) : $signed(z);
        end
        mx = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = mag64(w[i]);
            if (m[i] > mx) mx = m[i];
        end
        k = 0;
        while ((mx >> k) >= (64'd1 << 31)) k++;
        sum = (2 * k < 64) ? (s >> (2 * k)) : 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = m[i] >> k;
            sum += m[i] * m[i];
        end
        d = isqrt(sum);
        if (d == 0) d = 1;
        for (int i = 0; i < 3; i++) begin
            q = (m[i] << 30) / d;
            w[i] = w[i] < 0 ? -$signed(q) : $signed(q);
        end
        r.new_vel_x = 32'(w[0]);
        r.new_vel_y = 32'(w[1]);
        r.new_vel_z = 32'(w[2]);
        q = (({32'd0, c.density}) << 30) / d >> k;
        r.new_density = q > 64'hffffffff ? 32'hffffffff : q[31:0];
        return r;
    endfunction

    // ---------------------------------------------------------------- checker
    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > CYC_LIMIT) begin
            $display("FAIL relativistic_velocity_kick");
            $finish;
        end
        if (i_rst_n && o_strobe) begin
            if (kicked_q.size() == 0) begin
                $error("result beat with nothing expected");
                n_errors++;
            end else begin
                rvk_pkg::t_out e;
                e = kicked_q.pop_front();
                if (e.new_vel_x !== o_result.new_vel_x) begin
                    $error("new_vel_x exp %h got %h", e.new_vel_x, o_result.new_vel_x);
                    n_errors++;
                end
                if (e.new_vel_y !== o_result.new_vel_y) begin
                    $error("new_vel_y exp %h got %h", e.new_vel_y, o_result.new_vel_y);
                    n_errors++;
                end
                if (e.new_vel_z !== o_result.new_vel_z) begin
                    $error("new_vel_z exp %h got %h", e.new_vel_z, o_result.new_vel_z);
                    n_errors++;
                end
                if (e.new_density !== o_result.new_density) begin
                    $error("new_density exp %h got %h", e.new_density, o_result.new_density);
                    n_errors++;
                end
                if (e.bad_speed !== o_result.bad_speed) begin
                    $error("bad_speed exp %b got %b", e.bad_speed, o_result.bad_speed);
                    n_errors++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- drivers
    // start drops only when a gap actually follows, so back-to-back beats keep it high
    task automatic idle_cycles(input int n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // short gaps mostly, the odd long one, often none
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic reg_write(input logic [3:0] a, input logic [31:0] d);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= a; pwdata <= d;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (a)
            ADDR_DT:    dt_q   = d;
            ADDR_3D:    is_3d  = d[0];
            ADDR_MODEL: is_rel = d[0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // waits for the pipe to drain before a register change
    task automatic drain();
        idle_cycles(1);
        while (kicked_q.size() != 0) @(posedge i_clk);
        idle_cycles(4);
    endtask

    // one cell beat; has_exp selects a typed expectation over the predictor
    task automatic send_cell(input rvk_pkg::t_in c, input bit has_exp,
                             input rvk_pkg::t_out e);
        start <= 1'b1;
        i_item <= c;
        do @(posedge i_clk); while (busy);
        kicked_q.push_back(has_exp ? e : kick_cell(c));
    endtask

    task automatic send_random(input int gap_on);
        rvk_pkg::t_in c;
        int sel;
        sel = $urandom_range(0, 9);
        c.vel_x = $urandom; c.vel_y = $urandom; c.vel_z = $urandom;
        c.density = $urandom;
        c.force_x = $urandom; c.force_y = $urandom; c.force_z = $urandom;
        if (sel < 7) begin
            // sub-light velocities reach the real arithmetic, some with modest forces
            c.vel_x = $signed(32'($urandom_range(0, 1 << 29))) - (1 << 28);
            c.vel_y = $signed(32'($urandom_range(0, 1 << 29))) - (1 << 28);
            c.vel_z = $signed(32'($urandom_range(0, 1 << 29))) - (1 << 28);
            if (sel < 4) begin
                c.force_x = $signed(c.force_x) >>> $urandom_range(0, 24);
                c.force_y = $signed(c.force_y) >>> $urandom_range(0, 24);
                c.force_z = $signed(c.force_z) >>> $urandom_range(0, 24);
            end
        end
        if (gap_on) idle_cycles(gap_len());
        send_cell(c, 1'b0, '0);
    endtask

    typedef struct {
        rvk_pkg::t_in  c;
        bit            typed;
        rvk_pkg::t_out e;
    } t_row;

    t_row          rows[$];
    rvk_pkg::t_in  cin;

    initial begin
        dt_q = 0; is_3d = 1'b1; is_rel = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // after reset: dt 0, so a Newtonian kick leaves the cell as it was
        cin = '{32'sh12345678, -32'sh0abcdef0, 32'sh7fffffff, 32'h00010000,
                32'sh7fffffff, 32'sh80000000, 32'sh00010000};
        rows.push_back('{cin, 1'b1, '{cin.vel_x, cin.vel_y, cin.vel_z, cin.density, 1'b0}});
        foreach (rows[i]) begin
            idle_cycles(gap_len());
            send_cell(rows[i].c, rows[i].typed, rows[i].e);
        end
        rows.delete();
        drain();

        // Newtonian with the largest dt: saturation and the kick cap
        reg_write(ADDR_DT, 32'hffffffff);
        send_cell('{32'sh7fffffff, 32'sh80000000, 32'sh0, 32'hffffffff,
                    32'sh7fffffff, 32'sh80000000, 32'sh7fffffff}, 1'b0, '0);
        send_cell('{32'sh80000000, 32'sh7fffffff, 32'sh1, 32'h0,
                    32'sh1, -32'sh1, 32'sh80000000}, 1'b0, '0);
        drain();
        reg_write(ADDR_3D, 32'hfffffffe);   // upper bits ignored, 2-D
        send_cell('{32'sh100, 32'sh200, 32'sh300, 32'h5,
                    32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff}, 1'b0, '0);
        drain();

        // relativistic: speed of light and beyond is passed through with the flag
        reg_write(ADDR_MODEL, 32'h1);
        reg_write(ADDR_DT, 32'h00010000);
        cin = '{32'sh40000000, 32'sh0, 32'sh0, 32'h00123456,
                32'sh00010000, 32'sh0, 32'sh0};
        rows.push_back('{cin, 1'b1, '{cin.vel_x, cin.vel_y, cin.vel_z, cin.density, 1'b1}});
        cin = '{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'hffffffff,
                32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff};
        rows.push_back('{cin, 1'b1, '{cin.vel_x, cin.vel_y, cin.vel_z, cin.density, 1'b1}});
        // at rest, no force: nothing moves
        rows.push_back('{'{32'sh0, 32'sh0, 32'sh0, 32'h00010000, 32'sh0, 32'sh0, 32'sh0},
                         1'b0, '0});
        // near light speed, 2-D z scaling, huge kick, density blow-up
        rows.push_back('{'{32'sh3fffffff, 32'sh0, 32'sh0, 32'hffffffff,
                           32'sh80000000, 32'sh0, 32'sh0}, 1'b0, '0});
        rows.push_back('{'{32'sh20000000, -32'sh20000000, 32'sh20000000, 32'h00020000,
                           32'sh7fffffff, 32'sh80000000, 32'sh12345}, 1'b0, '0});
        rows.push_back('{'{-32'sh1, 32'sh1, 32'sh3fff0000, 32'hffffffff,
                           32'sh0, 32'sh0, 32'sh7fffffff}, 1'b0, '0});
        foreach (rows[i]) begin
            idle_cycles(gap_len());
            send_cell(rows[i].c, rows[i].typed, rows[i].e);
        end
        rows.delete();
        drain();
        reg_write(ADDR_3D, 32'h1);
        reg_write(ADDR_DT, 32'hffffffff);
        send_cell('{32'sh20000000, 32'sh10000000, -32'sh30000000, 32'hffffffff,
                    32'sh7fffffff, 32'sh80000000, 32'sh7fffffff}, 1'b0, '0);
        drain();

        // random phases over the register settings, extremes included
        for (int ph = 0; ph < 8; ph++) begin
            reg_write(ADDR_MODEL, 32'(ph[0]));
            reg_write(ADDR_3D, 32'(ph[1]));
            case (ph[2:1])
                2'd0: reg_write(ADDR_DT, 32'h0);
                2'd1: reg_write(ADDR_DT, 32'hffffffff);
                default: reg_write(ADDR_DT, $urandom >> $urandom_range(0, 16));
            endcase
            for (int n = 0; n < N_RANDOM / 8; n++) send_random(ph % 3 != 2);
            drain();
        end

        while (kicked_q.size() != 0) @(posedge i_clk);
        idle_cycles(LATENCY + 20);
        if (n_errors == 0) begin
            $display("PASS relativistic_velocity_kick");
        end else begin
            $display("FAIL relativistic_velocity_kick");
        end
        $finish;
    end

endmodule

`default_nettype wire
